@@ rtl/core/ptsched_pkg.sv @@
// ptsched_pkg: shared constants for the periodic task scheduler
// no dependencies
package ptsched_pkg;
  localparam int MAX_TASKS_DEF   = 6;
  localparam int TIME_BITS_DEF   = 16;
  localparam int PERIOD_BITS_DEF = 10;

  localparam logic [1:0] POL_RM  = 2'd0;
  localparam logic [1:0] POL_EDF = 2'd1;
  localparam logic [1:0] POL_LLF = 2'd2;

  localparam logic [1:0] REG_POLICY  = 2'd0;
  localparam logic [1:0] REG_COUNT   = 2'd1;
  localparam logic [1:0] REG_PERIODS = 2'd2;
  localparam logic [1:0] REG_COMPUTE = 2'd3;
endpackage

@@ rtl/core/ptsched_mod.sv @@
// ptsched_mod: sequential remainder unit, one quotient bit per cycle
// depends on nothing but its parameters
module ptsched_mod #(
  parameter int TIME_BITS   = 16,
  parameter int PERIOD_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [TIME_BITS-1:0]   dividend,
  input  logic [PERIOD_BITS-1:0] divisor,
  output logic                   done,
  output logic                   is_zero
);
  localparam int CW = $clog2(TIME_BITS + 1);
  logic [TIME_BITS-1:0]   quo;
  logic [PERIOD_BITS:0]   rem;
  logic [PERIOD_BITS-1:0] dsr;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic [PERIOD_BITS:0]   shifted;

  assign shifted = {rem[PERIOD_BITS-1:0], quo[TIME_BITS-1]};
  assign is_zero = (rem == '0);

  // restoring division step
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      quo  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      cnt  <= CW'(TIME_BITS);
    end else if (busy) begin
      quo <= {quo[TIME_BITS-2:0], 1'b0};
      if (shifted >= {1'b0, dsr}) rem <= shifted - {1'b0, dsr};
      else rem <= shifted;
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

@@ rtl/core/ptsched_ctrl.sv @@
// ptsched_ctrl: per-task sequencer over the task state memory
// depends on ptsched_pkg and ptsched_mod
module ptsched_ctrl #(
  parameter int MAX_TASKS   = ptsched_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS   = ptsched_pkg::TIME_BITS_DEF,
  parameter int PERIOD_BITS = ptsched_pkg::PERIOD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [1:0]                       policy,
  input  logic [2:0]                       task_count,
  input  logic [MAX_TASKS*PERIOD_BITS-1:0] periods,
  input  logic [MAX_TASKS*PERIOD_BITS-1:0] computes,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [TIME_BITS-1:0]             now_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       ran_task,
  output logic                             idle,
  output logic                             task_finished,
  output logic                             deadline_miss,
  output logic [2:0]                       missed_task,
  output logic                             failed
);
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int DW = TIME_BITS + 1;
  localparam int KW = DW + 2;
  localparam int EW = 1 + PERIOD_BITS + DW;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_MOD, S_WB, S_SEL, S_RUN, S_FET, S_OUT} st_t;
  st_t st;

  // task state memory: {active, remaining work, deadline}
  logic [EW-1:0] mem [MAX_TASKS];
  logic [EW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  // a read of the entry being written returns the new data
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
  end

  // reset valid bits, an entry not valid reads as zero
  logic [MAX_TASKS-1:0] vld;
  logic                 rd_vld;
  logic [EW-1:0]        ent;
  assign ent = rd_vld ? rd_data : '0;

  logic [TIME_BITS-1:0] now;
  logic [IW-1:0]        idx;
  logic [3:0]           n;
  logic                 miss, ran, fail;
  logic [IW-1:0]        missed, best_i;
  logic signed [KW-1:0] best_k;
  logic                 mod_start, mod_done, mod_zero;

  logic [PERIOD_BITS-1:0] per, wrk;
  assign per = periods[idx*PERIOD_BITS +: PERIOD_BITS];
  assign wrk = computes[idx*PERIOD_BITS +: PERIOD_BITS];

  ptsched_mod #(.TIME_BITS(TIME_BITS), .PERIOD_BITS(PERIOD_BITS)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(now), .divisor(per),
    .done(mod_done), .is_zero(mod_zero)
  );

  logic                   e_act;
  logic [PERIOD_BITS-1:0] e_rem;
  logic [DW-1:0]          e_dl;
  assign e_act = ent[EW-1];
  assign e_rem = ent[DW +: PERIOD_BITS];
  assign e_dl  = ent[DW-1:0];

  // selection key for the entry read this cycle
  logic signed [KW-1:0] key;
  always_comb begin
    case (policy)
      ptsched_pkg::POL_EDF: key = KW'($signed({2'b0, e_dl}));
      ptsched_pkg::POL_LLF: key = $signed({2'b0, e_dl}) - $signed({3'b0, now})
                                  - $signed({{(KW-PERIOD_BITS){1'b0}}, e_rem});
      default:              key = KW'($signed({{(KW-PERIOD_BITS){1'b0}}, per}));
    endcase
  end

  logic last;
  assign last = (4'(idx) + 4'd1 >= n);

  logic [PERIOD_BITS-1:0] new_rem;
  assign new_rem = (e_rem != '0) ? e_rem - 1'b1 : e_rem;

  always_ff @(posedge clk) begin
    mod_start <= 1'b0;
    wr_en     <= 1'b0;
    if (rst) begin
      st        <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
      fail      <= 1'b0;
      vld       <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      rd_vld <= vld[rd_addr] | (wr_en && wr_addr == rd_addr);
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (st)
        S_IDLE: if (in_valid && in_ready) begin
          now      <= now_in;
          in_ready <= 1'b0;
          idx      <= '0;
          rd_addr  <= '0;
          miss     <= 1'b0;
          ran      <= 1'b0;
          n        <= (task_count > 3'(MAX_TASKS)) ? 4'(MAX_TASKS) : 4'(task_count);
          if (fail || task_count == 3'd0) st <= S_OUT;
          else st <= S_RD;
        end
        // release pass: remainder then write back
        S_RD: begin
          mod_start <= (per != '0);
          st <= (per != '0) ? S_MOD : S_WB;
        end
        S_MOD: if (mod_done) st <= S_WB;
        S_WB: begin
          if (per != '0 && mod_zero) begin
            if (e_act && !miss) begin
              miss <= 1'b1; missed <= idx;
            end
            wr_en   <= 1'b1;
            wr_addr <= idx;
            wr_data <= {wrk != '0, wrk, DW'({1'b0, now} + DW'(per))};
          end
          if (last) begin
            idx <= '0; rd_addr <= '0;
            st  <= S_SEL;
          end else begin
            idx <= idx + 1'b1; rd_addr <= idx + 1'b1;
            st  <= S_RD;
          end
        end
        // selection pass over each entry in turn, through S_SEL then S_RUN
        S_SEL: begin
          if (miss) begin
            fail <= 1'b1;
            st   <= S_OUT;
          end else st <= S_RUN;
        end
        S_RUN: begin
          if (e_act && (!ran || key < best_k)) begin
            ran <= 1'b1; best_k <= key; best_i <= idx;
          end
          if (last) begin
            rd_addr <= (e_act && (!ran || key < best_k)) ? idx : best_i;
            st <= S_FET;
          end else begin
            idx <= idx + 1'b1; rd_addr <= idx + 1'b1;
            st <= S_SEL;
          end
        end
        // read the chosen entry
        S_FET: st <= S_OUT;
        S_OUT: if (!out_valid || out_ready) begin
          ran_task      <= ran ? 3'(rd_addr) : 3'd0;
          idle          <= !ran;
          task_finished <= ran && new_rem == '0;
          deadline_miss <= miss;
          missed_task   <= miss ? 3'(missed) : 3'd0;
          failed        <= fail;
          if (ran) begin
            wr_en   <= 1'b1;
            wr_addr <= rd_addr;
            wr_data <= {new_rem != '0, new_rem, e_dl};
          end
          out_valid <= 1'b1;
          in_ready  <= 1'b1;
          st        <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/periodic_task_scheduler_rm_edf_llf.sv @@
// periodic_task_scheduler_rm_edf_llf: top level, config registers and core
// depends on ptsched_pkg, ptsched_ctrl
//
// One request on the input channel is one scheduler tick with current_time.
// Each tick yields exactly one result: the task that ran, completion, a
// deadline miss and the sticky failed flag.
// The config channel writes policy, task_count, task_periods and
// task_compute_times by index; it is always ready and should only be used
// while no tick is in flight.
// Each tick runs a release pass over the tasks (a remainder unit shared
// by all tasks), then a selection pass over the state memory, then a
// fetch of the chosen task and an output step. A miss in the release
// pass skips selection; a failed block or zero task_count skips both.
// Ticks are taken one at a time.
// Reset clears config registers, task state valid bits and the failure flag.
// A stalled receiver holds the result; the next tick is accepted meanwhile
// but its result waits until the earlier one is taken.
module periodic_task_scheduler_rm_edf_llf #(
  parameter int MAX_TASKS   = ptsched_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS   = ptsched_pkg::TIME_BITS_DEF,
  parameter int PERIOD_BITS = ptsched_pkg::PERIOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [59:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [TIME_BITS-1:0] current_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           ran_task,
  output logic                 idle,
  output logic                 task_finished,
  output logic                 deadline_miss,
  output logic [2:0]           missed_task,
  output logic                 failed
);
  localparam int PW = MAX_TASKS * PERIOD_BITS;
  logic [1:0]    policy;
  logic [2:0]    task_count;
  logic [PW-1:0] periods, computes;

  assign cfg_ready = 1'b1;

  // config register file
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= '0; task_count <= '0; periods <= '0; computes <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ptsched_pkg::REG_POLICY:  policy     <= cfg_data[1:0];
        ptsched_pkg::REG_COUNT:   task_count <= cfg_data[2:0];
        ptsched_pkg::REG_PERIODS: periods    <= PW'({4'b0, cfg_data});
        ptsched_pkg::REG_COMPUTE: computes   <= PW'({4'b0, cfg_data});
        default: ;
      endcase
    end
  end

  ptsched_ctrl #(.MAX_TASKS(MAX_TASKS), .TIME_BITS(TIME_BITS),
                 .PERIOD_BITS(PERIOD_BITS)) u_ctrl (
    .clk(clk), .rst(rst), .policy(policy), .task_count(task_count),
    .periods(periods), .computes(computes),
    .in_valid(in_valid), .in_ready(in_ready), .now_in(current_time),
    .out_valid(out_valid), .out_ready(out_ready), .ran_task(ran_task),
    .idle(idle), .task_finished(task_finished), .deadline_miss(deadline_miss),
    .missed_task(missed_task), .failed(failed)
  );
endmodule

@@ rtl/core/ptsched_chk.sv @@
// ptsched_chk: port-level checks for the scheduler, bound to the top level
// depends on periodic_task_scheduler_rm_edf_llf
module ptsched_chk (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       idle,
  input logic       task_finished,
  input logic       deadline_miss,
  input logic       failed
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(failed))
    else $error("result dropped");
  // a miss implies failed and idle
  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && deadline_miss |-> failed && idle)
    else $error("miss without failure");
  // an idle tick finishes nothing
  a_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle |-> !task_finished)
    else $error("finished while idle");
  // failed never clears among results
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed ##1 out_valid |-> failed)
    else $error("failed cleared");
endmodule

bind periodic_task_scheduler_rm_edf_llf ptsched_chk u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .idle(idle), .task_finished(task_finished), .deadline_miss(deadline_miss),
  .failed(failed)
);

@@ bench/tb_periodic_task_scheduler_rm_edf_llf.sv @@
// tb_periodic_task_scheduler_rm_edf_llf: self-checking bench for the periodic task scheduler
// predicts every tick with an internal scheduler model and scoreboards each result
// depends on ptsched_pkg and periodic_task_scheduler_rm_edf_llf
module tb_periodic_task_scheduler_rm_edf_llf;
  localparam int NT = ptsched_pkg::MAX_TASKS_DEF;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT = 20000;
  localparam int TARGET_TICKS = 1840;

  typedef struct {
    logic [1:0]  pol;
    logic [2:0]  cnt;
    logic [59:0] periods;
    logic [59:0] computes;
  } sched_cfg_t;

  typedef struct {
    bit          active [NT];
    logic [9:0]  work [NT];
    logic [16:0] deadline [NT];
    bit          fail;
  } sched_state_t;

  typedef struct {
    logic [2:0] ran;
    logic       idl;
    logic       fin;
    logic       miss;
    logic [2:0] mtask;
    logic       fl;
  } tick_result_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [59:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [15:0] current_time = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [2:0] ran_task;
  logic idle;
  logic task_finished;
  logic deadline_miss;
  logic [2:0] missed_task;
  logic failed;

  periodic_task_scheduler_rm_edf_llf u_top (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  logic [15:0] pending_ticks [$];
  tick_result_t expected_results [$];
  sched_cfg_t cur_cfg;
  sched_state_t sched;
  logic [15:0] next_time;
  int queued = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int errors = 0;
  int checked = 0;
  int misses_seen = 0;
  int idle_cycles = 0;

  // one scheduler tick of the predictor
  function automatic tick_result_t sched_tick(inout sched_state_t s, input sched_cfg_t c,
                                              input logic [15:0] now);
    tick_result_t r;
    int n;
    logic [9:0] per, cmp;
    longint key, best;
    int chosen;
    bit ran;
    r = '{default: 0};
    n = (c.cnt > NT) ? NT : c.cnt;
    ran = 0;
    chosen = 0;
    best = 0;
    if (!s.fail) begin
      // releases and miss detection
      for (int i = 0; i < n; i++) begin
        per = c.periods[i*10 +: 10];
        cmp = c.computes[i*10 +: 10];
        if (per == 0 || (now % per) != 0) continue;
        if (s.active[i] && !r.miss) begin
          r.miss = 1;
          r.mtask = i[2:0];
        end
        s.deadline[i] = {1'b0, now} + {7'd0, per};
        s.work[i] = cmp;
        s.active[i] = (cmp != 0);
      end
      if (r.miss) s.fail = 1;
      else begin
        // policy selection, lowest index wins ties
        for (int i = 0; i < n; i++) begin
          if (!s.active[i]) continue;
          if (c.pol == ptsched_pkg::POL_EDF) key = s.deadline[i];
          else if (c.pol == ptsched_pkg::POL_LLF)
            key = longint'(s.deadline[i]) - now - s.work[i];
          else key = c.periods[i*10 +: 10];
          if (!ran || key < best) begin
            ran = 1;
            best = key;
            chosen = i;
          end
        end
        if (ran) begin
          if (s.work[chosen] != 0) s.work[chosen] = s.work[chosen] - 1;
          if (s.work[chosen] == 0) begin
            s.active[chosen] = 0;
            r.fin = 1;
          end
        end
      end
    end
    r.ran = ran ? chosen[2:0] : 3'd0;
    r.idl = !ran;
    r.fl = s.fail;
    return r;
  endfunction

  // true when the set runs the given number of ticks without a miss
  function automatic bit set_is_safe(sched_state_t s, sched_cfg_t c, logic [15:0] t, int n);
    tick_result_t r;
    for (int k = 0; k < n; k++) begin
      r = sched_tick(s, c, t);
      if (r.miss) return 0;
      t++;
    end
    return 1;
  endfunction

  // present one register write and hold it through its accepting edge
  task automatic write_reg(input logic [1:0] idx, input logic [59:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // wait for the block to drain, then load a whole configuration
  task automatic load_config(input sched_cfg_t c);
    while (pending_ticks.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(ptsched_pkg::REG_POLICY, {58'd0, c.pol});
    write_reg(ptsched_pkg::REG_COUNT, {57'd0, c.cnt});
    write_reg(ptsched_pkg::REG_PERIODS, c.periods);
    write_reg(ptsched_pkg::REG_COMPUTE, c.computes);
    cfg_valid <= 0;
    cur_cfg = c;
  endtask

  task automatic queue_ticks(input int n);
    for (int k = 0; k < n; k++) begin
      expected_results.push_back(sched_tick(sched, cur_cfg, next_time));
      pending_ticks.push_back(next_time);
      next_time++;
      queued++;
    end
  endtask

  function automatic sched_cfg_t random_set();
    sched_cfg_t c;
    logic [9:0] per, cmp;
    int pick;
    c.pol = 2'($urandom_range(0, 3));
    c.cnt = 3'($urandom_range(0, 7));
    for (int i = 0; i < NT; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) per = 0;
      else if (pick == 1) per = 10'd1023;
      else if (pick == 2) per = 1;
      else per = 10'($urandom_range(3, 60));
      if (pick == 1 && $urandom_range(0, 1)) cmp = 10'd1023;
      else if (pick == 0) cmp = 10'($urandom);
      else cmp = 10'($urandom_range(0, (per > 6) ? per / 4 : 0));
      c.periods[i*10 +: 10] = per;
      c.computes[i*10 +: 10] = cmp;
    end
    return c;
  endfunction

  // stimulus: directed sets, random schedulable sets, then a forced overload
  initial begin
    sched_cfg_t c;
    int n;
    bit ok;
    sched = '{default: 0};
    sched.active = '{default: 0};
    sched.work = '{default: 0};
    sched.deadline = '{default: 0};
    cur_cfg = '{pol: ptsched_pkg::POL_RM, cnt: 0, periods: 0, computes: 0};
    next_time = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // count above range, zero period, zero compute, tie on equal periods
    c.pol = ptsched_pkg::POL_RM;
    c.cnt = 3'd7;
    c.periods = {10'd1023, 10'd10, 10'd0, 10'd1, 10'd10, 10'd5};
    c.computes = {10'd1, 10'd3, 10'd5, 10'd0, 10'd2, 10'd1};
    load_config(c);
    queue_ticks(12);
    c.pol = ptsched_pkg::POL_LLF;
    load_config(c);
    queue_ticks(7);
    c.pol = ptsched_pkg::POL_EDF;
    c.cnt = 3'd0;
    load_config(c);
    queue_ticks(3);

    for (int ph = 0; queued < TARGET_TICKS || ph < 6; ph++) begin
      case (ph % 4)
        0: begin in_gap_pct = 0;  out_stall_pct = 0;  end
        1: begin in_gap_pct = 75; out_stall_pct = 0;  end
        2: begin in_gap_pct = 0;  out_stall_pct = 75; end
        default: begin in_gap_pct = 33; out_stall_pct = 33; end
      endcase
      n = $urandom_range(40, 140);
      // one phase starts near the top of the time range so time wraps if it runs past 64 ticks
      if (ph == 5) next_time = 16'hffc0;
      ok = 0;
      for (int tries = 0; tries < 60 && !ok; tries++) begin
        c = random_set();
        ok = set_is_safe(sched, c, next_time, n + 200);
      end
      if (!ok) begin
        c = random_set();
        c.periods = '0;
      end
      load_config(c);
      queue_ticks(n);
      if (ph == 5) next_time = 16'd1000;
    end

    // two tasks that cannot both fit: miss, then frozen ticks
    c.pol = ptsched_pkg::POL_EDF;
    c.cnt = 3'd2;
    c.periods = {40'd0, 10'd2, 10'd2};
    c.computes = {40'd0, 10'd2, 10'd2};
    load_config(c);
    next_time = 0;
    queue_ticks(10);

    while (pending_ticks.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d ticks through all policies, %0d results checked, %0d misses seen",
             queued, checked, misses_seen);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // tick request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) void'(pending_ticks.pop_front());
      if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= in_gap_pct) begin
        in_valid <= 1;
        current_time <= pending_ticks[0];
      end else begin
        in_valid <= 0;
      end
    end
  end

  task automatic report(input string field, input int got, input int want);
    $display("tick result %0d: %s got %0d expected %0d", checked, field, got, want);
    errors++;
  endtask

  // result monitor and scoreboard
  always @(posedge clk) begin
    tick_result_t e;
    out_ready <= !rst && ($urandom_range(0, 99) >= out_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("result with no tick outstanding");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (ran_task !== e.ran) report("ran_task", ran_task, e.ran);
        if (idle !== e.idl) report("idle", idle, e.idl);
        if (task_finished !== e.fin) report("task_finished", task_finished, e.fin);
        if (deadline_miss !== e.miss) report("deadline_miss", deadline_miss, e.miss);
        if (missed_task !== e.mtask) report("missed_task", missed_task, e.mtask);
        if (failed !== e.fl) report("failed", failed, e.fl);
        if (e.miss) misses_seen++;
      end
      checked++;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end
endmodule
